// ----- rtl/core/dgpc_pkg.sv -----
// ----------------------------------------------------------------------------
// dgpc_pkg: shared types and helpers of the disc and grid pixel compositor
// Holds the pixel token that travels down the cell chains, the register index
// codes of the configuration port and the RGB565 half-and-half blend.
// ----------------------------------------------------------------------------
package dgpc_pkg;

  localparam int unsigned COORD_W  = 9;
  localparam int unsigned COLOUR_W = 16;
  localparam int unsigned RADIUS_W = 6;
  localparam int unsigned RSQ_W    = 2 * RADIUS_W;
  localparam int unsigned SQ_W     = 18;            // 511 squared fits in 18 bits
  localparam int unsigned DIST_W   = SQ_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [RADIUS_W-1:0] RESET_RADIUS  = 6'd12;
  localparam logic [COORD_W-1:0]  RESET_SPACING = 9'd36;
  localparam logic [COLOUR_W-1:0] RESET_FIRST   = 16'hF800;
  localparam logic [COLOUR_W-1:0] RESET_SECOND  = 16'h07E0;
  localparam logic [COLOUR_W-1:0] RESET_THIRD   = 16'h001F;
  localparam logic [COLOUR_W-1:0] RESET_GRID    = 16'hFFFF;
  localparam logic [COLOUR_W-1:0] COLOUR_BLACK  = 16'h0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISC_RADIUS   = 3'd0,
    REG_GRID_SPACING  = 3'd1,
    REG_COLOUR_FIRST  = 3'd2,
    REG_COLOUR_SECOND = 3'd3,
    REG_COLOUR_THIRD  = 3'd4,
    REG_GRID_COLOUR   = 3'd5
  } cfg_reg_t;

  // One pixel request in flight.
  typedef struct packed {
    logic                valid;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                off_screen;
    logic [COLOUR_W-1:0] colour;
  } pix_t;

  // Pixel request plus the partial remainders of the grid line test.
  typedef struct packed {
    pix_t               pix;
    logic [COORD_W-1:0] rem_x;
    logic [COORD_W-1:0] rem_y;
  } grid_tok_t;

  // Per-channel average of two RGB565 colours, rounding down.
  function automatic logic [COLOUR_W-1:0] mix_half(input logic [COLOUR_W-1:0] a,
                                                   input logic [COLOUR_W-1:0] b);
    logic [5:0] r;
    logic [6:0] g;
    logic [5:0] bl;
    r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
    g  = {1'b0, a[10:5]} + {1'b0, b[10:5]};
    bl = {1'b0, a[4:0]} + {1'b0, b[4:0]};
    return {r[5:1], g[6:1], bl[5:1]};
  endfunction

endpackage

// ----- rtl/core/dgpc_disc_cell.sv -----
// ----------------------------------------------------------------------------
// dgpc_disc_cell: one disc of the compositor chain
// Holds one disc centre, squares the distance to the passing pixel in its
// first stage and compares and blends the disc colour in its second.
// ----------------------------------------------------------------------------
module dgpc_disc_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                load,
  input  logic [dgpc_pkg::COORD_W-1:0]        load_col,
  input  logic [dgpc_pkg::COORD_W-1:0]        load_row,
  input  logic [dgpc_pkg::RSQ_W-1:0]          radius_sq,
  input  logic [dgpc_pkg::COLOUR_W-1:0]       disc_colour,
  input  dgpc_pkg::pix_t                      pix_in,
  output dgpc_pkg::pix_t                      pix_out,
  output logic                                busy
);

  logic [dgpc_pkg::COORD_W-1:0] centre_col;
  logic [dgpc_pkg::COORD_W-1:0] centre_row;

  dgpc_pkg::pix_t             sq_pix;
  logic [dgpc_pkg::SQ_W-1:0]  sq_dx;
  logic [dgpc_pkg::SQ_W-1:0]  sq_dy;

  logic signed [dgpc_pkg::COORD_W:0]     dx;
  logic signed [dgpc_pkg::COORD_W:0]     dy;
  logic signed [2*dgpc_pkg::COORD_W+1:0] dx_prod;
  logic signed [2*dgpc_pkg::COORD_W+1:0] dy_prod;
  logic [dgpc_pkg::DIST_W-1:0]           dist_sq;
  logic                                  hit;
  dgpc_pkg::pix_t                        pix_out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col <= '0;
      centre_row <= '0;
    end else if (load) begin
      centre_col <= load_col;
      centre_row <= load_row;
    end
  end

  assign dx      = $signed({1'b0, pix_in.x}) - $signed({1'b0, centre_col});
  assign dy      = $signed({1'b0, pix_in.y}) - $signed({1'b0, centre_row});
  assign dx_prod = dx * dx;
  assign dy_prod = dy * dy;

  // Stage one: squared offsets.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pix.valid <= 1'b0;
    end else if (advance) begin
      sq_pix.valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_pix.x          <= pix_in.x;
      sq_pix.y          <= pix_in.y;
      sq_pix.off_screen <= pix_in.off_screen;
      sq_pix.colour     <= pix_in.colour;
      sq_dx             <= dx_prod[dgpc_pkg::SQ_W-1:0];
      sq_dy             <= dy_prod[dgpc_pkg::SQ_W-1:0];
    end
  end

  // Stage two: inside test and blend.
  assign dist_sq = {1'b0, sq_dx} + {1'b0, sq_dy};
  assign hit     = dist_sq <= {{(dgpc_pkg::DIST_W-dgpc_pkg::RSQ_W){1'b0}}, radius_sq};

  always_comb begin
    pix_out_next        = sq_pix;
    pix_out_next.colour = hit ? dgpc_pkg::mix_half(sq_pix.colour, disc_colour)
                              : sq_pix.colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (advance) begin
      pix_out.valid <= pix_out_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix_out.x          <= pix_out_next.x;
      pix_out.y          <= pix_out_next.y;
      pix_out.off_screen <= pix_out_next.off_screen;
      pix_out.colour     <= pix_out_next.colour;
    end
  end

  assign busy = sq_pix.valid | pix_out.valid;

endmodule

// ----- rtl/core/dgpc_grid_cell.sv -----
// ----------------------------------------------------------------------------
// dgpc_grid_cell: one remainder step of the grid line test
// Brings in one bit of the row and column and reduces both running
// remainders modulo the grid spacing.
// ----------------------------------------------------------------------------
module dgpc_grid_cell #(
  parameter int unsigned BIT_POS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [dgpc_pkg::COORD_W-1:0]  spacing,
  input  dgpc_pkg::grid_tok_t           tok_in,
  output dgpc_pkg::grid_tok_t           tok_out
);

  logic [dgpc_pkg::COORD_W:0]   shift_x;
  logic [dgpc_pkg::COORD_W:0]   shift_y;
  logic [dgpc_pkg::COORD_W:0]   diff_x;
  logic [dgpc_pkg::COORD_W:0]   diff_y;
  logic [dgpc_pkg::COORD_W-1:0] rem_x_next;
  logic [dgpc_pkg::COORD_W-1:0] rem_y_next;

  assign shift_x = {tok_in.rem_x, tok_in.pix.x[BIT_POS]};
  assign shift_y = {tok_in.rem_y, tok_in.pix.y[BIT_POS]};
  assign diff_x  = shift_x - {1'b0, spacing};
  assign diff_y  = shift_y - {1'b0, spacing};

  // The running remainder stays below the spacing, so it fits the row width.
  assign rem_x_next = (shift_x >= {1'b0, spacing}) ? diff_x[dgpc_pkg::COORD_W-1:0]
                                                   : shift_x[dgpc_pkg::COORD_W-1:0];
  assign rem_y_next = (shift_y >= {1'b0, spacing}) ? diff_y[dgpc_pkg::COORD_W-1:0]
                                                   : shift_y[dgpc_pkg::COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.pix.valid <= 1'b0;
    end else if (advance) begin
      tok_out.pix.valid <= tok_in.pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_out.pix.x          <= tok_in.pix.x;
      tok_out.pix.y          <= tok_in.pix.y;
      tok_out.pix.off_screen <= tok_in.pix.off_screen;
      tok_out.pix.colour     <= tok_in.pix.colour;
      tok_out.rem_x          <= rem_x_next;
      tok_out.rem_y          <= rem_y_next;
    end
  end

endmodule

// ----- rtl/core/disc_and_grid_pixel_compositor_unit.sv -----
// ----------------------------------------------------------------------------
// disc_and_grid_pixel_compositor_unit: RGB565 disc and grid pixel compositor
// Loads disc centres and returns the composited colour of requested pixels.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Direction
//  --------  ---------------------------------------------  ----------------
//  request   in_valid/in_ready, cmd, disc_index, centre_x,  into the block
//            centre_y, pixel_x, pixel_y
//  result    out_valid/out_ready, pixel_colour               out of the block
//  config    cfg_we, cfg_index, cfg_data                     into the block
//
//  A pixel request runs through 2*NUM_DISCS + 10 register stages: two per disc
//  cell, nine grid remainder steps and the output register. Pixel requests
//  follow each other every cycle; the whole chain moves together and stalls
//  only while the output register holds a result that is not taken.
//  A centre load waits until no pixel request is inside the disc cells, so
//  it takes effect between pixels, and is done in the cycle it is accepted.
//  Reset clears all valid bits, sets every centre to zero and restores the
//  register defaults.
//
// ----------------------------------------------------------------------------
module disc_and_grid_pixel_compositor_unit #(
  parameter int unsigned NUM_DISCS     = 18,
  parameter int unsigned SCREEN_WIDTH  = 360,
  parameter int unsigned SCREEN_HEIGHT = 360
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [4:0]                          disc_index,
  input  logic [dgpc_pkg::COORD_W-1:0]        centre_x,
  input  logic [dgpc_pkg::COORD_W-1:0]        centre_y,
  input  logic [dgpc_pkg::COORD_W-1:0]        pixel_x,
  input  logic [dgpc_pkg::COORD_W-1:0]        pixel_y,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dgpc_pkg::COLOUR_W-1:0]       pixel_colour,

  input  logic                                cfg_we,
  input  logic [dgpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dgpc_pkg::COLOUR_W-1:0]       cfg_data
);

  localparam int unsigned BOUND_W = 11;   // holds screen sizes up to 2047

  // Configuration registers.
  logic [dgpc_pkg::RADIUS_W-1:0] disc_radius;
  logic [dgpc_pkg::COORD_W-1:0]  grid_spacing;
  logic [dgpc_pkg::COLOUR_W-1:0] colour_first;
  logic [dgpc_pkg::COLOUR_W-1:0] colour_second;
  logic [dgpc_pkg::COLOUR_W-1:0] colour_third;
  logic [dgpc_pkg::COLOUR_W-1:0] grid_colour;

  logic [dgpc_pkg::RSQ_W-1:0]    radius_sq;

  // Chain plumbing.
  dgpc_pkg::pix_t                disc_chain [NUM_DISCS+1];
  logic [NUM_DISCS-1:0]          cell_busy;
  dgpc_pkg::grid_tok_t           grid_chain [dgpc_pkg::COORD_W+1];

  logic                          advance;
  logic                          load_accept;
  logic                          chain_busy;
  dgpc_pkg::pix_t                last_pix;
  logic                          on_row_line;
  logic                          on_col_line;
  logic [dgpc_pkg::COLOUR_W-1:0] row_blend;
  logic [dgpc_pkg::COLOUR_W-1:0] colour_next;

  // The configuration port writes one register per enabled cycle; unknown
  // indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      disc_radius   <= dgpc_pkg::RESET_RADIUS;
      grid_spacing  <= dgpc_pkg::RESET_SPACING;
      colour_first  <= dgpc_pkg::RESET_FIRST;
      colour_second <= dgpc_pkg::RESET_SECOND;
      colour_third  <= dgpc_pkg::RESET_THIRD;
      grid_colour   <= dgpc_pkg::RESET_GRID;
    end else if (cfg_we) begin
      unique case (dgpc_pkg::cfg_reg_t'(cfg_index))
        dgpc_pkg::REG_DISC_RADIUS:   disc_radius   <= cfg_data[dgpc_pkg::RADIUS_W-1:0];
        dgpc_pkg::REG_GRID_SPACING:  grid_spacing  <= cfg_data[dgpc_pkg::COORD_W-1:0];
        dgpc_pkg::REG_COLOUR_FIRST:  colour_first  <= cfg_data;
        dgpc_pkg::REG_COLOUR_SECOND: colour_second <= cfg_data;
        dgpc_pkg::REG_COLOUR_THIRD:  colour_third  <= cfg_data;
        dgpc_pkg::REG_GRID_COLOUR:   grid_colour   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The user must change the radius only while the block is idle; the block does
  // not enforce it. Its square is plain logic shared by every cell.
  assign radius_sq = {{dgpc_pkg::RADIUS_W{1'b0}}, disc_radius}
                   * {{dgpc_pkg::RADIUS_W{1'b0}}, disc_radius};

  // Every stage moves together whenever the output register can take a new
  // value. A pixel request enters when the chain moves; a centre load enters
  // only when no pixel sits in a disc cell that the load could overtake.
  assign advance     = !out_valid || out_ready;
  assign chain_busy  = |cell_busy;
  assign in_ready    = cmd ? advance : !chain_busy;
  assign load_accept = in_valid && in_ready && !cmd;

  // Entry token: a pixel starts black, and off-screen pixels are marked so
  // that the output stage forces them to black.
  always_comb begin
    disc_chain[0].valid      = in_valid && cmd && advance;
    disc_chain[0].x          = pixel_x;
    disc_chain[0].y          = pixel_y;
    disc_chain[0].off_screen =
      ({{(BOUND_W-dgpc_pkg::COORD_W){1'b0}}, pixel_x} >= BOUND_W'(SCREEN_WIDTH)) ||
      ({{(BOUND_W-dgpc_pkg::COORD_W){1'b0}}, pixel_y} >= BOUND_W'(SCREEN_HEIGHT));
    disc_chain[0].colour     = dgpc_pkg::COLOUR_BLACK;
  end

  // One cell per disc, in index order. Disc colours repeat every three cells.
  for (genvar i = 0; i < NUM_DISCS; i++) begin : g_disc
    logic [dgpc_pkg::COLOUR_W-1:0] cell_colour;

    assign cell_colour = ((i % 3) == 0) ? colour_first  :
                         ((i % 3) == 1) ? colour_second : colour_third;

    dgpc_disc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .load        (load_accept && (32'(disc_index) == i)),
      .load_col    (centre_x),
      .load_row    (centre_y),
      .radius_sq   (radius_sq),
      .disc_colour (cell_colour),
      .pix_in      (disc_chain[i]),
      .pix_out     (disc_chain[i+1]),
      .busy        (cell_busy[i])
    );
  end

  // Grid line test: a restoring remainder of the row and column by the
  // spacing, one bit per cell, most significant bit first.
  always_comb begin
    grid_chain[0].pix   = disc_chain[NUM_DISCS];
    grid_chain[0].rem_x = '0;
    grid_chain[0].rem_y = '0;
  end

  for (genvar b = 0; b < dgpc_pkg::COORD_W; b++) begin : g_grid
    dgpc_grid_cell #(
      .BIT_POS (dgpc_pkg::COORD_W - 1 - b)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .spacing (grid_spacing),
      .tok_in  (grid_chain[b]),
      .tok_out (grid_chain[b+1])
    );
  end

  // Output stage. With a zero spacing the remainder says nothing, and only
  // row zero and column zero count as grid lines.
  assign last_pix    = grid_chain[dgpc_pkg::COORD_W].pix;
  assign on_row_line = (grid_spacing == '0) ? (last_pix.y == '0)
                                            : (grid_chain[dgpc_pkg::COORD_W].rem_y == '0);
  assign on_col_line = (grid_spacing == '0) ? (last_pix.x == '0)
                                            : (grid_chain[dgpc_pkg::COORD_W].rem_x == '0);
  assign row_blend   = on_row_line ? dgpc_pkg::mix_half(last_pix.colour, grid_colour)
                                   : last_pix.colour;
  assign colour_next = last_pix.off_screen ? dgpc_pkg::COLOUR_BLACK :
                       on_col_line ? dgpc_pkg::mix_half(row_blend, grid_colour)
                                   : row_blend;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= last_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_colour <= colour_next;
    end
  end

endmodule

// ----- dv/dgpc_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgpc_tb_pkg: request codes shared by the compositor testbench
// Names the two kinds of request that travel on the input channel.
// ----------------------------------------------------------------------------
package dgpc_tb_pkg;

  typedef enum logic {
    OP_LOAD_CENTRE = 1'b0,
    OP_SHADE_PIXEL = 1'b1
  } request_op_t;

endpackage

// ----- dv/pixel_colour_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_colour_checker: predicts and checks composited pixel colours
// Follows register writes and centre loads, works out the colour of every
// accepted pixel request and compares it with the colours the block returns.
// ----------------------------------------------------------------------------
module pixel_colour_checker #(
  parameter int unsigned NUM_DISCS     = 18,
  parameter int unsigned SCREEN_WIDTH  = 360,
  parameter int unsigned SCREEN_HEIGHT = 360
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [4:0]  disc_index,
  input  logic [8:0]  centre_x,
  input  logic [8:0]  centre_y,
  input  logic [8:0]  pixel_x,
  input  logic [8:0]  pixel_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] pixel_colour,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [8:0]  x;
    logic [8:0]  y;
    logic [15:0] colour;
  } shaded_pixel_t;

  logic [5:0]    radius;
  logic [8:0]    spacing;
  logic [15:0]   tint_first;
  logic [15:0]   tint_second;
  logic [15:0]   tint_third;
  logic [15:0]   line_tint;
  logic [8:0]    centre_col [NUM_DISCS];
  logic [8:0]    centre_row [NUM_DISCS];
  shaded_pixel_t awaited_pixels [$];
  shaded_pixel_t oldest;

  // Averages two RGB565 colours channel by channel, rounding down.
  function automatic logic [15:0] average_rgb565(input logic [15:0] under,
                                                 input logic [15:0] over);
    int unsigned red;
    int unsigned green;
    int unsigned blue;
    red   = (int'(under[15:11]) + int'(over[15:11])) >> 1;
    green = (int'(under[10:5]) + int'(over[10:5])) >> 1;
    blue  = (int'(under[4:0]) + int'(over[4:0])) >> 1;
    return 16'((red << 11) | (green << 5) | blue);
  endfunction

  function automatic bit on_grid_line(input logic [8:0] pos, input logic [8:0] pitch);
    if (pitch == 0) return pos == 0;
    return (pos % pitch) == 0;
  endfunction

  function automatic logic [15:0] shade_colour(input logic [8:0] x, input logic [8:0] y);
    logic [15:0] colour;
    int          dx;
    int          dy;
    int          reach;
    colour = dgpc_pkg::COLOUR_BLACK;
    reach  = int'(radius) * int'(radius);
    if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return dgpc_pkg::COLOUR_BLACK;
    for (int d = 0; d < NUM_DISCS; d++) begin
      dx = int'(x) - int'(centre_col[d]);
      dy = int'(y) - int'(centre_row[d]);
      if (dx * dx + dy * dy <= reach) begin
        case (d % 3)
          0: colour = average_rgb565(colour, tint_first);
          1: colour = average_rgb565(colour, tint_second);
          default: colour = average_rgb565(colour, tint_third);
        endcase
      end
    end
    if (on_grid_line(y, spacing)) colour = average_rgb565(colour, line_tint);
    if (on_grid_line(x, spacing)) colour = average_rgb565(colour, line_tint);
    return colour;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      radius      = dgpc_pkg::RESET_RADIUS;
      spacing     = dgpc_pkg::RESET_SPACING;
      tint_first  = dgpc_pkg::RESET_FIRST;
      tint_second = dgpc_pkg::RESET_SECOND;
      tint_third  = dgpc_pkg::RESET_THIRD;
      line_tint   = dgpc_pkg::RESET_GRID;
      for (int d = 0; d < NUM_DISCS; d++) begin
        centre_col[d] = '0;
        centre_row[d] = '0;
      end
      awaited_pixels.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dgpc_pkg::REG_DISC_RADIUS:   radius      = cfg_data[5:0];
          dgpc_pkg::REG_GRID_SPACING:  spacing     = cfg_data[8:0];
          dgpc_pkg::REG_COLOUR_FIRST:  tint_first  = cfg_data;
          dgpc_pkg::REG_COLOUR_SECOND: tint_second = cfg_data;
          dgpc_pkg::REG_COLOUR_THIRD:  tint_third  = cfg_data;
          dgpc_pkg::REG_GRID_COLOUR:   line_tint   = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (awaited_pixels.size() == 0) begin
          $display("%0t: unexpected pixel colour %h, expected none", $time, pixel_colour);
          errors <= errors + 1;
        end else begin
          oldest = awaited_pixels.pop_front();
          if (pixel_colour !== oldest.colour) begin
            $display("%0t: pixel (%0d,%0d) colour mismatch, expected %h, actual %h",
                     $time, oldest.x, oldest.y, oldest.colour, pixel_colour);
            errors <= errors + 1;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (cmd == dgpc_tb_pkg::OP_SHADE_PIXEL) begin
          awaited_pixels.push_back('{x: pixel_x, y: pixel_y,
                                     colour: shade_colour(pixel_x, pixel_y)});
        end else if (disc_index < NUM_DISCS) begin
          centre_col[disc_index] = centre_x;
          centre_row[disc_index] = centre_y;
        end
      end
    end
    pending <= awaited_pixels.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the disc and grid pixel compositor
// Loads disc centres and requests pixels under several register settings and
// idling patterns, while a checker predicts every returned pixel colour.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_DISCS     = 18;
  localparam int SCREEN_WIDTH  = 360;
  localparam int SCREEN_HEIGHT = 360;
  // Register stages a pixel request passes through, plus a small margin. A
  // centre load returns nothing, so the settle wait is allowed to pass
  // before registers change, and again at the very end.
  localparam int PIPE_STAGES   = 2 * NUM_DISCS + 10;
  localparam int SETTLE_CYCLES = PIPE_STAGES + 8;
  // Length of the forced output stall; much longer than the pipeline depth so
  // the block fills up and pushes back on the request channel.
  localparam int HOLD_CYCLES   = 400;
  // The longest correct quiet stretch is the forced stall plus the settle
  // time; this limit is several times that.
  localparam int STALL_LIMIT   = 4000;
  localparam int NUM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE = 290;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        cmd;
  logic [4:0]  disc_index;
  logic [8:0]  centre_x;
  logic [8:0]  centre_y;
  logic [8:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] pixel_colour;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int          errors;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;
  logic        hold_rx = 1'b0;
  logic        hold_done = 1'b0;

  // Stimulus-side copy of where discs sit and how large they are, used only to
  // aim pixel requests at and around the discs.
  logic [8:0]  placed_col [NUM_DISCS];
  logic [8:0]  placed_row [NUM_DISCS];
  int          cur_radius;
  int          cur_spacing;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  disc_and_grid_pixel_compositor_unit #(
    .NUM_DISCS     (NUM_DISCS),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .disc_index   (disc_index),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_colour (pixel_colour),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pixel_colour_checker #(
    .NUM_DISCS     (NUM_DISCS),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .disc_index   (disc_index),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_colour (pixel_colour),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  // Result side. Each cycle the receiver takes a result or stalls at random.
  // The first time the stimulus asks for a hold, it keeps out_ready low for a
  // long stretch that it counts itself, then goes back to random stalls.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so that a following request goes out back to back; it is only
  // lowered when the sender decides to idle. Sampling in_ready right after
  // the edge sees its value from before the edge, as the block does.
  task automatic send_request(input dgpc_tb_pkg::request_op_t op, input logic [4:0] idx,
                              input logic [8:0] cx, input logic [8:0] cy,
                              input logic [8:0] px, input logic [8:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    disc_index <= idx;
    centre_x   <= cx;
    centre_y   <= cy;
    pixel_x    <= px;
    pixel_y    <= py;
    do @(posedge clk); while (!in_ready);
  endtask

  // The pixel fields of a centre load are noise; the block must ignore them.
  task automatic load_centre(input logic [4:0] idx, input logic [8:0] cx,
                             input logic [8:0] cy);
    send_request(dgpc_tb_pkg::OP_LOAD_CENTRE, idx, cx, cy, 9'($urandom), 9'($urandom));
    if (idx < NUM_DISCS) begin
      placed_col[idx] = cx;
      placed_row[idx] = cy;
    end
  endtask

  // Likewise the load fields of a pixel request are noise.
  task automatic shade(input logic [8:0] px, input logic [8:0] py);
    send_request(dgpc_tb_pkg::OP_SHADE_PIXEL, 5'($urandom), 9'($urandom), 9'($urandom),
                 px, py);
  endtask

  // Stops offering requests and waits until every pixel has come back, then
  // lets the pipeline empty of any trailing centre loads. The first edge is
  // waited out because pending only shows requests accepted before it.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input dgpc_pkg::cfg_reg_t which, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Register settings of the random phases. The first covers zero radius and
  // zero grid spacing, the next the largest radius with a grid on every pixel,
  // then a spacing wider than the screen, then spacing equal to the screen.
  task automatic apply_setting(input int setting);
    logic [5:0]  rad;
    logic [8:0]  pitch;
    logic [15:0] tint0;
    logic [15:0] tint1;
    logic [15:0] tint2;
    logic [15:0] line_tint;
    tint0     = 16'($urandom);
    tint1     = 16'($urandom);
    tint2     = 16'($urandom);
    line_tint = 16'($urandom);
    rad       = 6'($urandom_range(63));
    pitch     = 9'($urandom_range(1, 360));
    case (setting)
      0: begin
        rad = 6'd0;  pitch = 9'd0;
        tint0 = dgpc_pkg::RESET_FIRST;
        tint1 = dgpc_pkg::RESET_SECOND;
        tint2 = dgpc_pkg::RESET_THIRD;
        line_tint = dgpc_pkg::RESET_GRID;
      end
      1: begin
        rad = 6'd63; pitch = 9'd1;
        tint0 = 16'hFFFF; tint1 = dgpc_pkg::COLOUR_BLACK;
        line_tint = dgpc_pkg::COLOUR_BLACK;
      end
      2: begin rad = 6'd20; pitch = 9'd511; end
      3: begin rad = 6'd5;  pitch = 9'd360; end
      4: begin rad = 6'd40; pitch = 9'd7;   end
      default: ;
    endcase
    write_register(dgpc_pkg::REG_DISC_RADIUS, 16'(rad));
    write_register(dgpc_pkg::REG_GRID_SPACING, 16'(pitch));
    write_register(dgpc_pkg::REG_COLOUR_FIRST, tint0);
    write_register(dgpc_pkg::REG_COLOUR_SECOND, tint1);
    write_register(dgpc_pkg::REG_COLOUR_THIRD, tint2);
    write_register(dgpc_pkg::REG_GRID_COLOUR, line_tint);
    cfg_we      <= 1'b0;
    cur_radius  = int'(rad);
    cur_spacing = int'(pitch);
  endtask

  // One random request. Most are pixel requests, many of them aimed at a disc
  // edge or a grid line; the rest are centre loads, a few of them with an
  // index past the last disc or a centre off the screen.
  task automatic random_request();
    int         j;
    int         reach;
    logic [4:0] idx;
    logic [8:0] px;
    logic [8:0] py;
    if ($urandom_range(99) < 18) begin
      idx = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                     : 5'($urandom_range(NUM_DISCS - 1));
      px  = ($urandom_range(7) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(359));
      py  = ($urandom_range(7) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(359));
      load_centre(idx, px, py);
    end else begin
      px = 9'($urandom_range(359));
      py = 9'($urandom_range(359));
      case ($urandom_range(9))
        0: begin
          px = 9'($urandom_range(511));
          py = 9'($urandom_range(511));
        end
        1, 2: ;
        3: begin
          // Snap one coordinate onto a grid line.
          if (cur_spacing == 0) px = 9'd0;
          else px = 9'(cur_spacing * $urandom_range(359 / cur_spacing));
          if ($urandom_range(1) == 1) {px, py} = {py, px};
        end
        default: begin
          // Land in a square just larger than one disc so that both sides of
          // the circle edge get hit.
          j     = int'($urandom_range(NUM_DISCS - 1));
          reach = cur_radius + 2;
          px    = 9'(int'(placed_col[j]) + int'($urandom_range(2 * reach)) - reach);
          py    = 9'(int'(placed_row[j]) + int'($urandom_range(2 * reach)) - reach);
        end
      endcase
      shade(px, py);
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = dgpc_tb_pkg::OP_LOAD_CENTRE;
    disc_index = '0;
    centre_x   = '0;
    centre_y   = '0;
    pixel_x    = '0;
    pixel_y    = '0;
    cfg_we     = 1'b0;
    cfg_index  = dgpc_pkg::REG_DISC_RADIUS;
    cfg_data   = '0;
    cur_radius  = int'(dgpc_pkg::RESET_RADIUS);
    cur_spacing = int'(dgpc_pkg::RESET_SPACING);
    for (int d = 0; d < NUM_DISCS; d++) begin
      placed_col[d] = '0;
      placed_row[d] = '0;
    end
    send_idle_pct = 36;
    recv_idle_pct = 69;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset registers: radius 12, grid every 36.
    // Every disc starts at the origin, so the first pixel collects all of them.
    shade(9'd0, 9'd0);
    shade(9'd359, 9'd359);
    load_centre(5'd0, 9'd0, 9'd0);
    load_centre(5'd17, 9'd359, 9'd359);
    // Indexes past the last disc must leave every centre alone.
    load_centre(5'd18, 9'd100, 9'd100);
    load_centre(5'd31, 9'd511, 9'd511);
    // Two discs on the same spot: the blend order decides the colour.
    load_centre(5'd1, 9'd100, 9'd100);
    load_centre(5'd2, 9'd100, 9'd100);
    // A disc whose centre lies just off the right edge still shows on screen.
    load_centre(5'd5, 9'd365, 9'd200);
    shade(9'd359, 9'd200);
    shade(9'd100, 9'd100);
    shade(9'd112, 9'd100);   // exactly on the radius
    shade(9'd113, 9'd100);   // one pixel outside
    shade(9'd108, 9'd108);
    shade(9'd108, 9'd109);
    // Pixels off the screen come back black whatever lies there.
    shade(9'd360, 9'd0);
    shade(9'd0, 9'd360);
    shade(9'd511, 9'd511);
    shade(9'd359, 9'd359);
    shade(9'd36, 9'd72);     // crossing of two grid lines
    shade(9'd0, 9'd5);
    shade(9'd5, 9'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Registers only change with nothing in flight; this is also the pause
      // in which the sender waits for every result to come back.
      drain_and_settle();
      case (p / 2)
        0: begin send_idle_pct = 36; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      apply_setting(p);
      shade(9'd0, 9'd0);
      shade(9'd359, 9'd359);
      shade(placed_col[3], placed_row[3]);
      // With neither side idling, stall the output for a long stretch while
      // requests keep coming, so the pipeline fills and in_ready drops.
      if (p == 4) hold_rx <= 1'b1;
      repeat (ITEMS_PER_PHASE) random_request();
    end

    drain_and_settle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
